### design/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational implication checked at each clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked at the clock edge after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/tvs_pkg.sv
package tvs_pkg;

   // item opcodes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_ESTOP  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // software stop request codes
   localparam logic [1:0] STOP_REQ_NONE  = 2'd0;
   localparam logic [1:0] STOP_REQ_SET   = 2'd1;
   localparam logic [1:0] STOP_REQ_UNSET = 2'd2;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 17;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINEAR_GAIN       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGULAR_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINEAR_GAIN_FAST  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGULAR_GAIN_FAST = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SMOOTHING_WEIGHT  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_TIMEOUT   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLDOFF           = 3'd6;

   // register reset values
   localparam logic [15:0] RST_LINEAR_GAIN       = 16'd6554;
   localparam logic [15:0] RST_ANGULAR_GAIN      = 16'd9830;
   localparam logic [15:0] RST_LINEAR_GAIN_FAST  = 16'd11469;
   localparam logic [15:0] RST_ANGULAR_GAIN_FAST = 16'd11469;
   localparam logic [16:0] RST_SMOOTHING_WEIGHT  = 17'd13107;
   localparam logic [15:0] RST_RELEASE_TIMEOUT   = 16'd50;
   localparam logic [15:0] RST_HOLDOFF           = 16'd100;

   // fixed point formats
   localparam int unsigned GAIN_WIDTH   = 16;
   localparam int unsigned GAIN_FRAC    = 14;
   localparam int unsigned WEIGHT_WIDTH = 17;
   localparam int unsigned WEIGHT_FRAC  = 16;
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = 17'd65536;

   // timers
   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   typedef logic [15:0] timer_type;

   // saturating timer increment
   function automatic timer_type age_timer(input timer_type t);
      return (t == TIMER_MAX) ? t : t + 16'd1;
   endfunction

endpackage

### design/teleop_velocity_shaper.sv
// Teleoperation velocity shaper.
// Request channel (req_valid / req_stall) takes one item per transfer:
// a joystick sample, an emergency status or a control tick, chosen by req_op.
// Response channel (rsp_valid / rsp_stall) returns exactly one result per item,
// in order: the published velocity on ticks, rumble and stop requests on
// samples, and the current soft stop and turbo states every time.
// Configuration port (csr_valid / csr_ready) writes one register per transfer;
// csr_ready is always high, writes are meant for idle periods.
// An item taken sits in the input register; its result is registered in the
// result register when that is free, and rsp_valid rises with it. Throughput:
// one item per cycle while the receiver does not stall, limited by the single
// pass of scaling or smoothing multipliers between input and result registers.
// When the receiver stalls, the result stays put and the input register holds
// one more item; req_stall rises only while both are full.
// Reset (synchronous) restores register defaults, clears the commands, modes
// and press timer, saturates the holdoff timers and empties both stages.
module teleop_velocity_shaper #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_op,
   input  logic signed [VALUE_WIDTH-1:0]          req_axis_x,
   input  logic signed [VALUE_WIDTH-1:0]          req_axis_y,
   input  logic signed [VALUE_WIDTH-1:0]          req_axis_turn,
   input  logic                                   req_deadman_held,
   input  logic                                   req_stop_pressed,
   input  logic                                   req_fast_on_pressed,
   input  logic                                   req_fast_off_pressed,
   input  logic                                   req_button_stop_active,
   input  logic                                   req_scanner_stop_active,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_velocity_valid,
   output logic signed [VALUE_WIDTH-1:0]          rsp_vel_x,
   output logic signed [VALUE_WIDTH-1:0]          rsp_vel_y,
   output logic signed [VALUE_WIDTH-1:0]          rsp_vel_turn,
   output logic                                   rsp_rumble,
   output logic [1:0]                             rsp_stop_request,
   output logic                                   rsp_soft_stop_on,
   output logic                                   rsp_fast_mode_on,
   // configuration port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tvs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tvs_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int unsigned AXES = 3;

   // configuration registers
   logic [15:0] linear_gain_ff, angular_gain_ff, linear_gain_fast_ff, angular_gain_fast_ff;
   logic [16:0] smoothing_weight_ff;
   logic [15:0] release_timeout_ff, holdoff_ff;

   // input register
   logic                          in_valid_ff;
   logic [1:0]                    in_op_ff;
   logic signed [VALUE_WIDTH-1:0] in_axis_ff [AXES];
   logic                          in_deadman_ff, in_stop_ff, in_fast_on_ff, in_fast_off_ff;
   logic                          in_estop_ff;

   // block state
   logic                          fast_mode_ff, fast_mode_in;
   logic                          deadman_ff, deadman_in;
   logic                          motion_ff, motion_in;
   logic                          soft_stop_ff, soft_stop_in;
   logic                          estop_ff, estop_in;
   logic signed [VALUE_WIDTH-1:0] target_ff [AXES];
   logic signed [VALUE_WIDTH-1:0] target_in [AXES];
   logic signed [VALUE_WIDTH-1:0] smoothed_ff [AXES];
   logic signed [VALUE_WIDTH-1:0] smoothed_in [AXES];
   tvs_pkg::timer_type            press_ff, press_in;
   tvs_pkg::timer_type            toggle_ff, toggle_in;
   tvs_pkg::timer_type            rumble_tmr_ff, rumble_tmr_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_vvalid_ff, rsp_vvalid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_vel_ff [AXES];
   logic signed [VALUE_WIDTH-1:0] rsp_vel_in [AXES];
   logic                          rsp_rumble_ff, rsp_rumble_in;
   logic [1:0]                    rsp_stop_ff, rsp_stop_in;

   // datapath
   logic                          out_free, fire, req_take, in_valid_in;
   logic                          fast_sample;
   logic [15:0]                   lin_gain, ang_gain;
   logic [15:0]                   lane_gain [AXES];
   logic signed [VALUE_WIDTH-1:0] scaled [AXES];
   logic signed [VALUE_WIDTH-1:0] blended [AXES];
   logic signed [VALUE_WIDTH-1:0] blend_target [AXES];
   logic [16:0]                   weight_eff, keep_eff;
   tvs_pkg::timer_type            press_aged;

   // handshake control
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign fire         = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;
   assign csr_ready    = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff       <= tvs_pkg::RST_LINEAR_GAIN;
         angular_gain_ff      <= tvs_pkg::RST_ANGULAR_GAIN;
         linear_gain_fast_ff  <= tvs_pkg::RST_LINEAR_GAIN_FAST;
         angular_gain_fast_ff <= tvs_pkg::RST_ANGULAR_GAIN_FAST;
         smoothing_weight_ff  <= tvs_pkg::RST_SMOOTHING_WEIGHT;
         release_timeout_ff   <= tvs_pkg::RST_RELEASE_TIMEOUT;
         holdoff_ff           <= tvs_pkg::RST_HOLDOFF;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tvs_pkg::CSR_LINEAR_GAIN:       linear_gain_ff       <= csr_data[15:0];
            tvs_pkg::CSR_ANGULAR_GAIN:      angular_gain_ff      <= csr_data[15:0];
            tvs_pkg::CSR_LINEAR_GAIN_FAST:  linear_gain_fast_ff  <= csr_data[15:0];
            tvs_pkg::CSR_ANGULAR_GAIN_FAST: angular_gain_fast_ff <= csr_data[15:0];
            tvs_pkg::CSR_SMOOTHING_WEIGHT:  smoothing_weight_ff  <= csr_data;
            tvs_pkg::CSR_RELEASE_TIMEOUT:   release_timeout_ff   <= csr_data[15:0];
            tvs_pkg::CSR_HOLDOFF:           holdoff_ff           <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // input register load
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_op_ff       <= req_op;
         in_axis_ff[0]  <= req_axis_x;
         in_axis_ff[1]  <= req_axis_y;
         in_axis_ff[2]  <= req_axis_turn;
         in_deadman_ff  <= req_deadman_held;
         in_stop_ff     <= req_stop_pressed;
         in_fast_on_ff  <= req_fast_on_pressed;
         in_fast_off_ff <= req_fast_off_pressed;
         in_estop_ff    <= req_button_stop_active | req_scanner_stop_active;
      end
   end

   // turbo selection for the sample, off wins
   assign fast_sample = in_fast_off_ff ? 1'b0 : (in_fast_on_ff ? 1'b1 : fast_mode_ff);
   assign lin_gain    = fast_sample ? linear_gain_fast_ff : linear_gain_ff;
   assign ang_gain    = fast_sample ? angular_gain_fast_ff : angular_gain_ff;
   assign lane_gain[0] = lin_gain;
   assign lane_gain[1] = lin_gain;
   assign lane_gain[2] = ang_gain;

   // smoothing weight clamped to one
   assign weight_eff = (smoothing_weight_ff > tvs_pkg::WEIGHT_ONE) ?
                       tvs_pkg::WEIGHT_ONE : smoothing_weight_ff;
   assign keep_eff   = tvs_pkg::WEIGHT_ONE - weight_eff;

   // per-axis lanes: scaling for samples, blend or decay for ticks
   for (genvar i = 0; i < AXES; i++) begin : g_lane
      assign blend_target[i] = deadman_ff ? target_ff[i] : '0;

      tvs_scaler #(.VALUE_WIDTH(VALUE_WIDTH)) u_scaler (
         .gain   (lane_gain[i]),
         .axis   (in_axis_ff[i]),
         .scaled (scaled[i])
      );

      tvs_smoother #(.VALUE_WIDTH(VALUE_WIDTH)) u_smoother (
         .target   (blend_target[i]),
         .previous (smoothed_ff[i]),
         .weight   (weight_eff),
         .keep     (keep_eff),
         .smoothed (blended[i])
      );
   end

   assign press_aged = tvs_pkg::age_timer(press_ff);

   // next state and result for the item in the input register
   always_comb begin
      fast_mode_in  = fast_mode_ff;
      deadman_in    = deadman_ff;
      motion_in     = motion_ff;
      soft_stop_in  = soft_stop_ff;
      estop_in      = estop_ff;
      target_in     = target_ff;
      smoothed_in   = smoothed_ff;
      press_in      = press_ff;
      toggle_in     = toggle_ff;
      rumble_tmr_in = rumble_tmr_ff;
      rsp_vvalid_in = 1'b0;
      rsp_rumble_in = 1'b0;
      rsp_stop_in   = tvs_pkg::STOP_REQ_NONE;
      if (fire) begin
         case (in_op_ff)
            tvs_pkg::OP_SAMPLE: begin
               fast_mode_in = fast_sample;
               deadman_in   = in_deadman_ff;
               if (estop_ff && in_deadman_ff && (rumble_tmr_ff > holdoff_ff)) begin
                  // rumble drops the rest of the sample
                  rsp_rumble_in = 1'b1;
                  rumble_tmr_in = '0;
               end else begin
                  if (in_stop_ff && (toggle_ff > holdoff_ff)) begin
                     rsp_stop_in  = soft_stop_ff ? tvs_pkg::STOP_REQ_UNSET
                                                 : tvs_pkg::STOP_REQ_SET;
                     soft_stop_in = !soft_stop_ff;
                     toggle_in    = '0;
                  end
                  if (in_deadman_ff) begin
                     motion_in = 1'b1;
                     press_in  = '0;
                  end
                  target_in = scaled;
               end
            end
            tvs_pkg::OP_ESTOP: begin
               estop_in = in_estop_ff;
            end
            tvs_pkg::OP_TICK: begin
               press_in      = press_aged;
               toggle_in     = tvs_pkg::age_timer(toggle_ff);
               rumble_tmr_in = tvs_pkg::age_timer(rumble_tmr_ff);
               if (deadman_ff) begin
                  smoothed_in   = blended;
                  rsp_vvalid_in = 1'b1;
               end else if (motion_ff) begin
                  // release: decay until the timeout clears the command
                  if (press_aged > release_timeout_ff) begin
                     for (int i = 0; i < AXES; i++) begin
                        smoothed_in[i] = '0;
                     end
                     motion_in = 1'b0;
                  end else begin
                     smoothed_in = blended;
                  end
                  rsp_vvalid_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
      for (int i = 0; i < AXES; i++) begin
         rsp_vel_in[i] = rsp_vvalid_in ? smoothed_in[i] : '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff  <= 1'b0;
         deadman_ff    <= 1'b0;
         motion_ff     <= 1'b0;
         soft_stop_ff  <= 1'b0;
         estop_ff      <= 1'b0;
         press_ff      <= '0;
         toggle_ff     <= tvs_pkg::TIMER_MAX;
         rumble_tmr_ff <= tvs_pkg::TIMER_MAX;
         for (int i = 0; i < AXES; i++) begin
            target_ff[i]   <= '0;
            smoothed_ff[i] <= '0;
         end
      end else begin
         fast_mode_ff  <= fast_mode_in;
         deadman_ff    <= deadman_in;
         motion_ff     <= motion_in;
         soft_stop_ff  <= soft_stop_in;
         estop_ff      <= estop_in;
         press_ff      <= press_in;
         toggle_ff     <= toggle_in;
         rumble_tmr_ff <= rumble_tmr_in;
         target_ff     <= target_in;
         smoothed_ff   <= smoothed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         rsp_vvalid_ff <= rsp_vvalid_in;
         rsp_vel_ff    <= rsp_vel_in;
         rsp_rumble_ff <= rsp_rumble_in;
         rsp_stop_ff   <= rsp_stop_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_velocity_valid = rsp_vvalid_ff;
   assign rsp_vel_x          = rsp_vel_ff[0];
   assign rsp_vel_y          = rsp_vel_ff[1];
   assign rsp_vel_turn       = rsp_vel_ff[2];
   assign rsp_rumble         = rsp_rumble_ff;
   assign rsp_stop_request   = rsp_stop_ff;
   assign rsp_soft_stop_on   = soft_stop_ff;
   assign rsp_fast_mode_on   = fast_mode_ff;

endmodule

### design/tvs_scaler.sv
// one axis: gain times deflection, rounded, shifted and saturated
module tvs_scaler #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic [tvs_pkg::GAIN_WIDTH-1:0] gain,
   input  logic signed [VALUE_WIDTH-1:0]  axis,
   output logic signed [VALUE_WIDTH-1:0]  scaled
);

   localparam int unsigned PW = VALUE_WIDTH + tvs_pkg::GAIN_WIDTH + 2;
   localparam int unsigned SW = PW - tvs_pkg::GAIN_FRAC;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (tvs_pkg::GAIN_FRAC - 1);
   localparam logic signed [SW-1:0] HI = {{(SW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] LO = ~HI;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rounded;
   logic signed [SW-1:0] shifted;

   // signed product with rounding offset, arithmetic shift by part-select
   always_comb begin
      prod    = PW'($signed({1'b0, gain})) * PW'(axis);
      rounded = prod + HALF;
      shifted = rounded[PW-1:tvs_pkg::GAIN_FRAC];
      if (shifted > HI) begin
         scaled = HI[VALUE_WIDTH-1:0];
      end else if (shifted < LO) begin
         scaled = LO[VALUE_WIDTH-1:0];
      end else begin
         scaled = shifted[VALUE_WIDTH-1:0];
      end
   end

endmodule

### design/tvs_smoother.sv
// one axis: weighted blend of target and previous command, rounded and saturated
module tvs_smoother #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic signed [VALUE_WIDTH-1:0]    target,
   input  logic signed [VALUE_WIDTH-1:0]    previous,
   input  logic [tvs_pkg::WEIGHT_WIDTH-1:0] weight,
   input  logic [tvs_pkg::WEIGHT_WIDTH-1:0] keep,
   output logic signed [VALUE_WIDTH-1:0]    smoothed
);

   localparam int unsigned PW = VALUE_WIDTH + tvs_pkg::WEIGHT_WIDTH + 2;
   localparam int unsigned SW = PW - tvs_pkg::WEIGHT_FRAC;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (tvs_pkg::WEIGHT_FRAC - 1);
   localparam logic signed [SW-1:0] HI = {{(SW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] LO = ~HI;

   logic signed [PW-1:0] new_part;
   logic signed [PW-1:0] old_part;
   logic signed [PW-1:0] sum;
   logic signed [SW-1:0] shifted;

   always_comb begin
      new_part = PW'(target) * PW'($signed({1'b0, weight}));
      old_part = PW'(previous) * PW'($signed({1'b0, keep}));
      sum      = new_part + old_part + HALF;
      shifted  = sum[PW-1:tvs_pkg::WEIGHT_FRAC];
      if (shifted > HI) begin
         smoothed = HI[VALUE_WIDTH-1:0];
      end else if (shifted < LO) begin
         smoothed = LO[VALUE_WIDTH-1:0];
      end else begin
         smoothed = shifted[VALUE_WIDTH-1:0];
      end
   end

endmodule

### design/tvs_checker.sv
`include "assert_macros.svh"

// port-level checks on the response channel
module tvs_checker #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_velocity_valid,
   input logic signed [VALUE_WIDTH-1:0] rsp_vel_x,
   input logic signed [VALUE_WIDTH-1:0] rsp_vel_y,
   input logic signed [VALUE_WIDTH-1:0] rsp_vel_turn,
   input logic                          rsp_rumble,
   input logic [1:0]                    rsp_stop_request,
   input logic                          rsp_soft_stop_on
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_vel_x) && $stable(rsp_stop_request) && $stable(rsp_rumble), "stalled result changed")

   // no velocity published means zero command fields
   `ASSERT_IMPLY(a_vel_zero, clock, reset, rsp_valid && !rsp_velocity_valid, rsp_vel_x == '0 && rsp_vel_y == '0 && rsp_vel_turn == '0, "velocity fields not zero")

   // a rumble drops the stop button of the same sample
   `ASSERT_IMPLY(a_rumble_no_stop, clock, reset, rsp_valid && rsp_rumble, rsp_stop_request == tvs_pkg::STOP_REQ_NONE, "stop request with rumble")

   // a set request leaves soft stop on, an unset request leaves it off
   `ASSERT_IMPLY(a_stop_state, clock, reset, rsp_valid && (rsp_stop_request == tvs_pkg::STOP_REQ_SET || rsp_stop_request == tvs_pkg::STOP_REQ_UNSET), rsp_soft_stop_on == (rsp_stop_request == tvs_pkg::STOP_REQ_SET), "soft stop state disagrees with request")

   // stop request code in range, no velocity alongside rumble
   `ASSERT_IMPLY(a_code_range, clock, reset, rsp_valid, rsp_stop_request != 2'd3 && !(rsp_rumble && rsp_velocity_valid), "bad result code combination")

endmodule

bind teleop_velocity_shaper tvs_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tvs_checker (.*);
